@@ rtl/luc_pkg.sv @@
// luc_pkg: widths, register codes and fixed-point helpers for the lens undistortion map
// no dependencies; imported by every rtl file of the block

package luc_pkg;

    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int FOC_W    = 20;
    localparam int COEF_W   = 32;
    localparam int IDX_W    = 3;

    localparam int DIV_STEPS = 4;
    localparam int DIV_STG   = 32 / DIV_STEPS;
    localparam int DIV_LAT   = DIV_STG + 2;
    localparam int NSTG      = DIV_LAT + 10;

    localparam logic [IDX_W-1:0] REG_K1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_K2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_P1 = 3'd2;
    localparam logic [IDX_W-1:0] REG_P2 = 3'd3;
    localparam logic [IDX_W-1:0] REG_FX = 3'd4;
    localparam logic [IDX_W-1:0] REG_FY = 3'd5;
    localparam logic [IDX_W-1:0] REG_CX = 3'd6;
    localparam logic [IDX_W-1:0] REG_CY = 3'd7;

    typedef logic signed [31:0] t_q28;
    typedef logic signed [47:0] t_acc;
    typedef logic signed [63:0] t_prod;

    localparam t_acc SAT_MAX = 48'sh0000_7fff_ffff;
    localparam t_acc SAT_MIN = 48'shffff_8000_0000;
    localparam t_acc ONE_Q28 = 48'sh0000_1000_0000;

    function automatic t_q28 sat32(input t_acc v);
        t_q28 r;
        if (v > SAT_MAX) begin
            r = 32'sh7fff_ffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic t_acc shr28(input t_prod p);
        return 48'(p >>> 28);
    endfunction

    function automatic t_acc shr27(input t_prod p);
        return 48'(p >>> 27);
    endfunction

endpackage

@@ rtl/luc_if.sv @@
// luc_if: request, result and register-write channels of the lens undistortion map
// depends on luc_pkg for field widths

interface luc_req_if import luc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] dest_col;
    logic [ROW_W-1:0] dest_row;
    modport source (output valid, dest_col, dest_row, input ready);
    modport sink (input valid, dest_col, dest_row, output ready);
endinterface

interface luc_res_if import luc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] source_col;
    logic [ROW_W-1:0] source_row;
    logic             inside_res;
    modport source (output valid, source_col, source_row, inside_res, input ready);
    modport sink (input valid, source_col, source_row, inside_res, output ready);
endinterface

interface luc_cfg_if import luc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [COEF_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/luc_div.sv @@
// luc_div: pipelined restoring divider giving sat32((pix*256 - centre) * 2^28 / focal)
// depends on luc_pkg; stage enables come from the pipeline control of the top level

module luc_div import luc_pkg::*; (
    input  logic               i_clk,
    input  logic [DIV_LAT-1:0] i_en,
    input  logic [COL_W-1:0]   i_pix,
    input  logic [FOC_W-1:0]   i_centre,
    input  logic [FOC_W-1:0]   i_focal,
    output t_q28               o_q
);

    logic [FOC_W-1:0] r_rem [0:DIV_STG];
    logic [31:0]      r_q   [0:DIV_STG];
    logic [3:0]       r_lo  [0:DIV_STG];
    logic             r_neg [0:DIV_STG];
    logic             r_ovf [0:DIV_STG];
    t_q28             r_res;

    logic signed [21:0] w_d;
    logic [20:0]        w_mag;
    logic               w_ovf;

    // signed offset from the principal point and its magnitude
    always_comb begin
        w_d   = $signed({2'b0, i_pix, 8'b0}) - $signed({2'b0, i_centre});
        w_mag = w_d[21] ? 21'(-w_d) : w_d[20:0];
        w_ovf = {3'b0, w_mag} >= {i_focal, 4'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= FOC_W'(w_mag[20:4]);
            r_q[0]   <= '0;
            r_lo[0]  <= w_mag[3:0];
            r_neg[0] <= w_d[21];
            r_ovf[0] <= w_ovf;
        end
    end

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stage
        logic [FOC_W-1:0] n_rem;
        logic [31:0]      n_q;

        always_comb begin
            logic [FOC_W:0] t;
            logic [31:0]    dlo;
            n_rem = r_rem[s];
            n_q   = r_q[s];
            dlo   = {r_lo[s], 28'b0};
            for (int j = 0; j < DIV_STEPS; j++) begin
                t = {n_rem, dlo[31 - DIV_STEPS*s - j]};
                if (t >= {1'b0, i_focal}) begin
                    t = t - {1'b0, i_focal};
                    n_q[31 - DIV_STEPS*s - j] = 1'b1;
                end
                n_rem = t[FOC_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s+1]) begin
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
                r_lo[s+1]  <= r_lo[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    // sign and clamp to signed q3.28
    always_ff @(posedge i_clk) begin
        if (i_en[DIV_LAT-1]) begin
            if (r_neg[DIV_STG]) begin
                if (r_ovf[DIV_STG] || r_q[DIV_STG] > 32'h8000_0000) begin
                    r_res <= 32'sh8000_0000;
                end else begin
                    r_res <= -$signed(r_q[DIV_STG]);
                end
            end else begin
                if (r_ovf[DIV_STG] || r_q[DIV_STG][31]) begin
                    r_res <= 32'sh7fff_ffff;
                end else begin
                    r_res <= $signed(r_q[DIV_STG]);
                end
            end
        end
    end

    assign o_q = r_res;

endmodule

@@ rtl/lens_undistort_coordinate_map.sv @@
// lens_undistort_coordinate_map: top level, register file and distortion pipeline
// depends on luc_pkg, luc_if and luc_div
//
// For each corrected-image pixel request the block returns the source pixel to sample
// under a Brown-Conrady radial (k1, k2) and tangential (p1, p2) lens model, with an
// inside flag; outside points and a zero focal length give zero coordinates and a clear
// flag. One request is taken every clock when the result side does not stall; each request
// passes through the two 32-bit restoring dividers that normalize the coordinate (four
// quotient bits per stage) followed by the chain of registered 32x32 multipliers. A stall
// holds only the full stages, so empty stages keep filling while a finished result waits.
// The user must write registers through the register port only while no request is in
// flight; the block itself does not enforce this.

module lens_undistort_coordinate_map import luc_pkg::*; #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    luc_req_if.sink    i_req,
    luc_cfg_if.sink    i_cfg,
    luc_res_if.source  o_res
);

    localparam logic signed [26:0] U_LIM = 27'(IMAGE_WIDTH * 256);
    localparam logic signed [26:0] V_LIM = 27'(IMAGE_HEIGHT * 256);
    localparam int S_PROD = DIV_LAT;

    t_q28             r_k1, r_k2, r_p1, r_p2;
    logic [FOC_W-1:0] r_fx, r_fy, r_cx, r_cy;

    logic [NSTG-1:0]  r_v;
    logic [NSTG:0]    w_en;
    logic [NSTG-1:0]  w_vin;

    t_q28  w_x, w_y;
    t_prod r_pxx, r_pyy, r_pxy;
    t_q28  r_x10, r_y10, r_x11, r_y11, r_x12, r_y12, r_x13, r_y13, r_x14, r_y14;
    t_q28  r_x15, r_y15;
    t_q28  r_r2, r_xy, r_tx, r_ty;
    t_prod r_prr, r_pk1, r_pp1xy, r_pp2tx, r_pp1ty, r_pp2xy;
    t_q28  r_r4;
    t_acc  r_a1_13, r_ex13, r_ey13, r_a1_14, r_ex14, r_ey14, r_ex15, r_ey15, r_ex16, r_ey16;
    t_prod r_pk2;
    t_q28  r_rad;
    t_prod r_pxr, r_pyr;
    t_q28  r_xd, r_yd;
    t_prod r_pu, r_pv;
    logic [COL_W-1:0] r_ocol;
    logic [ROW_W-1:0] r_orow;
    logic             r_oin;

    t_acc               w_x2, w_y2;
    t_q28               w_r2;
    logic signed [26:0] w_ud, w_vd;
    logic               w_in;

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= -32'sd76076780;
            r_k2 <= 32'sd19853237;
            r_p1 <= 32'sd51966;
            r_p2 <= 32'sd4730;
            r_fx <= 20'd117415;
            r_fy <= 20'd117068;
            r_cx <= 20'd94007;
            r_cy <= 20'd63584;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_K1: r_k1 <= $signed(i_cfg.data);
                REG_K2: r_k2 <= $signed(i_cfg.data);
                REG_P1: r_p1 <= $signed(i_cfg.data);
                REG_P2: r_p2 <= $signed(i_cfg.data);
                REG_FX: r_fx <= i_cfg.data[FOC_W-1:0];
                REG_FY: r_fy <= i_cfg.data[FOC_W-1:0];
                REG_CX: r_cx <= i_cfg.data[FOC_W-1:0];
                REG_CY: r_cy <= i_cfg.data[FOC_W-1:0];
            endcase
        end
    end

    // stage control: a stage loads when empty or when the next one moves
    assign w_en[NSTG] = o_res.ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign w_vin = {r_v[NSTG-2:0], i_req.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign i_req.ready = w_en[0];

    // normalization
    luc_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (w_en[DIV_LAT-1:0]),
        .i_pix    (i_req.dest_col),
        .i_centre (r_cx),
        .i_focal  (r_fx),
        .o_q      (w_x)
    );

    luc_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (w_en[DIV_LAT-1:0]),
        .i_pix    (COL_W'(i_req.dest_row)),
        .i_centre (r_cy),
        .i_focal  (r_fy),
        .o_q      (w_y)
    );

    always_comb begin
        w_x2 = shr28(r_pxx);
        w_y2 = shr28(r_pyy);
        w_r2 = sat32(w_x2 + w_y2);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_PROD]) begin
            r_pxx <= w_x * w_x;
            r_pyy <= w_y * w_y;
            r_pxy <= w_x * w_y;
            r_x10 <= w_x;
            r_y10 <= w_y;
        end
        if (w_en[S_PROD+1]) begin
            r_r2  <= w_r2;
            r_xy  <= sat32(shr28(r_pxy));
            r_tx  <= sat32(48'(w_r2) + (w_x2 <<< 1));
            r_ty  <= sat32(48'(w_r2) + (w_y2 <<< 1));
            r_x11 <= r_x10;
            r_y11 <= r_y10;
        end
        if (w_en[S_PROD+2]) begin
            r_prr   <= r_r2 * r_r2;
            r_pk1   <= r_k1 * r_r2;
            r_pp1xy <= r_p1 * r_xy;
            r_pp2tx <= r_p2 * r_tx;
            r_pp1ty <= r_p1 * r_ty;
            r_pp2xy <= r_p2 * r_xy;
            r_x12   <= r_x11;
            r_y12   <= r_y11;
        end
        if (w_en[S_PROD+3]) begin
            r_r4    <= sat32(shr28(r_prr));
            r_a1_13 <= shr28(r_pk1);
            r_ex13  <= shr27(r_pp1xy) + shr28(r_pp2tx);
            r_ey13  <= shr28(r_pp1ty) + shr27(r_pp2xy);
            r_x13   <= r_x12;
            r_y13   <= r_y12;
        end
        if (w_en[S_PROD+4]) begin
            r_pk2   <= r_k2 * r_r4;
            r_a1_14 <= r_a1_13;
            r_ex14  <= r_ex13;
            r_ey14  <= r_ey13;
            r_x14   <= r_x13;
            r_y14   <= r_y13;
        end
        if (w_en[S_PROD+5]) begin
            r_rad  <= sat32(ONE_Q28 + r_a1_14 + shr28(r_pk2));
            r_ex15 <= r_ex14;
            r_ey15 <= r_ey14;
            r_x15  <= r_x14;
            r_y15  <= r_y14;
        end
        if (w_en[S_PROD+6]) begin
            r_pxr  <= r_x15 * r_rad;
            r_pyr  <= r_y15 * r_rad;
            r_ex16 <= r_ex15;
            r_ey16 <= r_ey15;
        end
        if (w_en[S_PROD+7]) begin
            r_xd <= sat32(shr28(r_pxr) + r_ex16);
            r_yd <= sat32(shr28(r_pyr) + r_ey16);
        end
        if (w_en[S_PROD+8]) begin
            r_pu <= $signed({1'b0, r_fx}) * r_xd;
            r_pv <= $signed({1'b0, r_fy}) * r_yd;
        end
        if (w_en[S_PROD+9]) begin
            r_ocol <= w_in ? w_ud[8 +: COL_W] : '0;
            r_orow <= w_in ? w_vd[8 +: ROW_W] : '0;
            r_oin  <= w_in;
        end
    end

    // back to pixel units and bounds check
    always_comb begin
        w_ud = 27'(shr28(r_pu)) + $signed({7'b0, r_cx});
        w_vd = 27'(shr28(r_pv)) + $signed({7'b0, r_cy});
        w_in = !w_ud[26] && !w_vd[26] && w_ud < U_LIM && w_vd < V_LIM
               && r_fx != '0 && r_fy != '0;
    end

    assign o_res.valid      = r_v[NSTG-1];
    assign o_res.source_col = r_ocol;
    assign o_res.source_row = r_orow;
    assign o_res.inside_res = r_oin;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.inside_res |-> o_res.source_col == '0 && o_res.source_row == '0)
        else $error("outside result with nonzero coordinates");

    a_zero_focal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (r_fx == '0 || r_fy == '0) |-> !o_res.inside_res)
        else $error("inside flag with zero focal length");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_v[0] && !o_res.ready)
        else $error("request refused while pipeline can move");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[NSTG-1]) |-> $past(r_v[NSTG-2]))
        else $error("result appeared without an item behind it");

endmodule
